// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file bchg_core.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/bchg_pkg.sv
package bchg_pkg;

    // Gesture machine phases.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESSING = 2'd1;
    localparam logic [1:0] PH_HELD     = 2'd2;
    localparam logic [1:0] PH_WAIT     = 2'd3;

    // Gesture codes reported on the result channel.
    localparam logic [2:0] G_NONE   = 3'd0;
    localparam logic [2:0] G_SINGLE = 3'd1;
    localparam logic [2:0] G_DOUBLE = 3'd2;
    localparam logic [2:0] G_TRIPLE = 3'd3;
    localparam logic [2:0] G_HOLD   = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic REG_HOLD_THRESHOLD = 1'b0;
    localparam logic REG_CLICK_WINDOW   = 1'b1;
    localparam logic [7:0] HOLD_THRESHOLD_RESET = 8'd15;
    localparam logic [7:0] CLICK_WINDOW_RESET   = 8'd5;

    localparam logic [7:0] RUN_MAX   = 8'd255;
    localparam logic [3:0] CLICK_MAX = 4'd15;

    // One result item.
    typedef struct packed {
        logic [2:0] gesture;
        logic [3:0] click_total;
    } result_t;

endpackage

// File: rtl/button_click_hold_gesture.sv
// Button click and hold gesture detector.
// Input channel (in_valid / in_ready / pressed): one polled button sample per
// request. Output channel (out_valid / out_ready / gesture / click_total):
// exactly one result per sample, in order. gesture is 0 for no event, 1, 2
// or 3 for a single, double or triple-or-more click, and 4 for a hold.
// click_total gives the clicks of a finished sequence, saturating at 15.
// Configuration: cfg_write, cfg_index and cfg_data write hold_threshold
// (index 0) and click_window (index 1); write them only while the block is idle.
// A sample is taken into the input register and its result into the result
// register, which drives the output port.
// Throughput: one sample per cycle while the receiver does not stall, set by
// the combinational gesture update between the input and result registers.
// Reset clears the gesture state, empties both registers and loads the
// thresholds with 15 and 5. When the receiver stalls, the result is held
// and the input register still takes one more sample before in_ready drops.
module button_click_hold_gesture (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       pressed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] gesture,
    output logic [3:0] click_total,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              pressed_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    bchg_pkg::result_t result_reg;
    bchg_pkg::result_t step_result;
    logic [7:0]        hold_threshold_reg;
    logic [7:0]        click_window_reg;
    logic              advance;
    logic              step;

    // Pipeline control: the input register moves on when the result slot frees.
    assign advance        = !out_valid_reg || out_ready;
    assign step           = in_valid_reg && advance;
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pressed_reg <= pressed;
        end
        if (step)
        begin
            result_reg <= step_result;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_threshold_reg <= bchg_pkg::HOLD_THRESHOLD_RESET;
            click_window_reg   <= bchg_pkg::CLICK_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bchg_pkg::REG_HOLD_THRESHOLD: hold_threshold_reg <= cfg_data;
                bchg_pkg::REG_CLICK_WINDOW:   click_window_reg   <= cfg_data;
                default:                      hold_threshold_reg <= hold_threshold_reg;
            endcase
        end
    end

    // Gesture state machine.
    bchg_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .pressed        (pressed_reg),
        .hold_threshold (hold_threshold_reg),
        .click_window   (click_window_reg),
        .result         (step_result)
    );

    assign out_valid   = out_valid_reg;
    assign gesture     = result_reg.gesture;
    assign click_total = result_reg.click_total;

endmodule

// File: rtl/bchg_core.sv
`include "assert_macros.svh"

module bchg_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  pressed,
    input  logic [7:0]            hold_threshold,
    input  logic [7:0]            click_window,
    output bchg_pkg::result_t     result
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] press_run_reg;
    logic [7:0] press_run_next;
    logic [7:0] release_run_reg;
    logic [7:0] release_run_next;
    logic [3:0] clicks_reg;
    logic [3:0] clicks_next;

    logic [7:0] press_inc;
    logic [7:0] release_inc;
    logic [3:0] clicks_inc;

    // Saturating increments of the counters.
    assign press_inc   = (press_run_reg == bchg_pkg::RUN_MAX) ? press_run_reg
                                                              : press_run_reg + 8'd1;
    assign release_inc = (release_run_reg == bchg_pkg::RUN_MAX) ? release_run_reg
                                                                : release_run_reg + 8'd1;
    assign clicks_inc  = (clicks_reg == bchg_pkg::CLICK_MAX) ? clicks_reg
                                                             : clicks_reg + 4'd1;

    // Next state and result for the sample in the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        press_run_next     = press_run_reg;
        release_run_next   = release_run_reg;
        clicks_next        = clicks_reg;
        result.gesture     = bchg_pkg::G_NONE;
        result.click_total = 4'd0;
        unique case (phase_reg)
            bchg_pkg::PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next     = bchg_pkg::PH_PRESSING;
                    press_run_next = 8'd1;
                end
            end
            bchg_pkg::PH_PRESSING:
            begin
                if (pressed)
                begin
                    press_run_next = press_inc;
                    if (press_inc >= hold_threshold)
                    begin
                        clicks_next    = 4'd0;
                        phase_next     = bchg_pkg::PH_HELD;
                        result.gesture = bchg_pkg::G_HOLD;
                    end
                end
                else
                begin
                    clicks_next      = clicks_inc;
                    phase_next       = bchg_pkg::PH_WAIT;
                    release_run_next = 8'd0;
                end
            end
            bchg_pkg::PH_HELD:
            begin
                if (!pressed)
                begin
                    phase_next     = bchg_pkg::PH_IDLE;
                    press_run_next = 8'd0;
                end
            end
            bchg_pkg::PH_WAIT:
            begin
                if (pressed)
                begin
                    phase_next     = bchg_pkg::PH_PRESSING;
                    press_run_next = 8'd1;
                end
                else
                begin
                    release_run_next = release_inc;
                    if (release_inc >= click_window)
                    begin
                        // The window closed: classify the click sequence.
                        result.click_total = clicks_reg;
                        if (clicks_reg <= 4'd1)
                        begin
                            result.gesture = bchg_pkg::G_SINGLE;
                        end
                        else if (clicks_reg == 4'd2)
                        begin
                            result.gesture = bchg_pkg::G_DOUBLE;
                        end
                        else
                        begin
                            result.gesture = bchg_pkg::G_TRIPLE;
                        end
                        clicks_next    = 4'd0;
                        phase_next     = bchg_pkg::PH_IDLE;
                        press_run_next = 8'd0;
                    end
                end
            end
            default:
            begin
                phase_next = bchg_pkg::PH_IDLE;
            end
        endcase
    end

    // Gesture state advances once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= bchg_pkg::PH_IDLE;
            press_run_reg   <= 8'd0;
            release_run_reg <= 8'd0;
            clicks_reg      <= 4'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            press_run_reg   <= press_run_next;
            release_run_reg <= release_run_next;
            clicks_reg      <= clicks_next;
        end
    end

    `ASSERT_PROP(a_held_no_clicks, clk, rst_n,
        (phase_reg == bchg_pkg::PH_HELD) |-> (clicks_reg == 4'd0),
        "clicks survived a hold")
    `ASSERT_PROP(a_wait_has_click, clk, rst_n,
        (phase_reg == bchg_pkg::PH_WAIT) |-> (clicks_reg != 4'd0),
        "click window open with no click counted")
    `ASSERT_PROP(a_idle_no_press, clk, rst_n,
        (phase_reg == bchg_pkg::PH_IDLE) |-> (press_run_reg == 8'd0),
        "press counter not cleared in idle")
    `ASSERT_NEVER(a_hold_no_total, clk, rst_n,
        step && (result.gesture == bchg_pkg::G_HOLD) && (result.click_total != 4'd0),
        "hold gesture carries a click count")

endmodule

// File: sim/tb_button_click_hold_gesture.sv
`timescale 1ns / 1ps

module tb_button_click_hold_gesture;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASE_ITEMS     = 160;

    // Gesture predictor and the queue of gesture events it expects.
    class gesture_scoreboard;
        logic [7:0]        hold_threshold;
        logic [7:0]        click_window;
        logic [1:0]        stage;
        logic [7:0]        press_run;
        logic [7:0]        release_run;
        logic [3:0]        clicks_so_far;
        bchg_pkg::result_t expected_events[$];
        int                errors;

        function new();
            hold_threshold = bchg_pkg::HOLD_THRESHOLD_RESET;
            click_window   = bchg_pkg::CLICK_WINDOW_RESET;
            stage          = bchg_pkg::PH_IDLE;
            press_run      = '0;
            release_run    = '0;
            clicks_so_far  = '0;
            errors         = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] val);
            if (idx == bchg_pkg::REG_HOLD_THRESHOLD)
                hold_threshold = val;
            else
                click_window = val;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // Advance the gesture machine by one button sample.
        function void note_sample(logic down);
            bchg_pkg::result_t ev;
            ev.gesture     = bchg_pkg::G_NONE;
            ev.click_total = '0;
            case (stage)
                bchg_pkg::PH_IDLE:
                begin
                    if (down)
                    begin
                        stage     = bchg_pkg::PH_PRESSING;
                        press_run = 8'd1;
                    end
                end
                bchg_pkg::PH_PRESSING:
                begin
                    if (down)
                    begin
                        if (press_run != bchg_pkg::RUN_MAX)
                            press_run++;
                        if (press_run >= hold_threshold)
                        begin
                            clicks_so_far = '0;
                            stage         = bchg_pkg::PH_HELD;
                            ev.gesture    = bchg_pkg::G_HOLD;
                        end
                    end
                    else
                    begin
                        if (clicks_so_far != bchg_pkg::CLICK_MAX)
                            clicks_so_far++;
                        stage       = bchg_pkg::PH_WAIT;
                        release_run = '0;
                    end
                end
                bchg_pkg::PH_HELD:
                begin
                    if (!down)
                    begin
                        stage     = bchg_pkg::PH_IDLE;
                        press_run = '0;
                    end
                end
                default:
                begin
                    if (down)
                    begin
                        stage     = bchg_pkg::PH_PRESSING;
                        press_run = 8'd1;
                    end
                    else
                    begin
                        if (release_run != bchg_pkg::RUN_MAX)
                            release_run++;
                        // Enough released samples: the click sequence is over.
                        if (release_run >= click_window)
                        begin
                            ev.click_total = clicks_so_far;
                            if (clicks_so_far <= 4'd1)
                                ev.gesture = bchg_pkg::G_SINGLE;
                            else if (clicks_so_far == 4'd2)
                                ev.gesture = bchg_pkg::G_DOUBLE;
                            else
                                ev.gesture = bchg_pkg::G_TRIPLE;
                            clicks_so_far = '0;
                            stage         = bchg_pkg::PH_IDLE;
                            press_run     = '0;
                        end
                    end
                end
            endcase
            expected_events.push_back(ev);
        endfunction

        // Compare one delivered result with the oldest expected event.
        task check_result(logic [2:0] g, logic [3:0] t);
            bchg_pkg::result_t ev;
            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected result gesture=%0d click_total=%0d", g, t));
            end
            else
            begin
                ev = expected_events.pop_front();
                if (g !== ev.gesture)
                    report($sformatf("gesture %0d, expected %0d", g, ev.gesture));
                if (t !== ev.click_total)
                    report($sformatf("click_total %0d, expected %0d", t, ev.click_total));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       pressed;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] gesture;
    logic [3:0] click_total;
    logic       cfg_write;
    logic       cfg_index;
    logic [7:0] cfg_data;

    gesture_scoreboard sb;
    bit in_taken;
    bit hold_off_req;
    int cycle_count;
    int items_sent;
    int burst_left;
    int cur_thr;
    int cur_win;

    button_click_hold_gesture DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pressed     (pressed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .gesture     (gesture),
        .click_total (click_total),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Both channels are sampled at the rising edge; the request is noted before
    // the result is checked, since a result always trails its request.
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready;
        if (in_taken)
            sb.note_sample(pressed);
        if (out_valid && out_ready)
            sb.check_result(gesture, click_total);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_button_click_hold_gesture: FAIL");
            $finish;
        end
    end

    // Receiver: random stall modes, each kept for a random stretch, plus one long
    // hold-off on demand.
    initial
    begin
        int mode;
        int left;
        mode      = 0;
        left      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic pause_requests(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Offer one button sample; the sender works in bursts with gaps between.
    task automatic offer(input logic p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                pause_requests($urandom_range(1, 8));
        end
        burst_left--;
        in_valid <= 1'b1;
        pressed  <= p;
        do
            @(negedge clk);
        while (!in_taken);
        items_sent++;
    endtask

    task automatic level_run(input logic p, input int n);
        repeat (n) offer(p);
    endtask

    // Wait until every expected event has been delivered and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] thr, input logic [7:0] win);
        cfg_write <= 1'b1;
        cfg_index <= bchg_pkg::REG_HOLD_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= bchg_pkg::REG_CLICK_WINDOW;
        cfg_data  <= win;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        sb.set_register(bchg_pkg::REG_HOLD_THRESHOLD, thr);
        sb.set_register(bchg_pkg::REG_CLICK_WINDOW, win);
        cur_thr = int'(thr);
        cur_win = int'(win);
    endtask

    // Mostly short lengths, now and then exactly the upper bound.
    function automatic int pick_length(input int hi);
        if (hi <= 1)
            return 1;
        if ($urandom_range(0, 7) == 0)
            return hi;
        return int'($urandom_range(1, (hi < 6) ? hi : 6));
    endfunction

    // One gesture: a click sequence, a hold, or random noise.
    task automatic play_sequence();
        int kind;
        int clicks;
        int k;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            clicks = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                 : $urandom_range(1, 4);
            for (k = 0; k < clicks; k++)
            begin
                level_run(1'b1, pick_length((cur_thr > 1) ? cur_thr - 1 : 1));
                if (k < clicks - 1)
                    level_run(1'b0, pick_length(cur_win));
            end
            // Close the window, or now and then leave it open for the next gesture.
            if ($urandom_range(0, 5) == 0)
                level_run(1'b0, int'($urandom_range(1, cur_win)));
            else
                level_run(1'b0, cur_win + 1);
        end
        else if (kind < 8)
        begin
            level_run(1'b1, ((cur_thr > 2) ? cur_thr : 2) + int'($urandom_range(0, 5)));
            level_run(1'b0, int'($urandom_range(1, 3)));
        end
        else
        begin
            repeat ($urandom_range(4, 16)) offer(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [7:0] thr, input logic [7:0] win);
        int start;
        settle();
        configure(thr, win);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            play_sequence();
    endtask

    initial
    begin
        logic script[$];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        pressed      = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = bchg_pkg::REG_HOLD_THRESHOLD;
        cfg_data     = '0;
        in_taken     = 1'b0;
        hold_off_req = 1'b0;
        cycle_count  = 0;
        items_sent   = 0;
        burst_left   = 0;
        cur_thr      = int'(bchg_pkg::HOLD_THRESHOLD_RESET);
        cur_win      = int'(bchg_pkg::CLICK_WINDOW_RESET);
        sb           = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Random gestures on the reset thresholds.
        while (items_sent < PHASE_ITEMS)
            play_sequence();

        // Directed: hold on the second pressed sample, single, double and triple
        // clicks with a one-sample window, and clicks discarded by a hold.
        settle();
        configure(8'd2, 8'd1);
        script = '{1'b1, 1'b1, 1'b0,
                   1'b1, 1'b0, 1'b0,
                   1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                   1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        foreach (script[i])
            offer(script[i]);
        // A threshold of one still needs a second pressed sample.
        settle();
        configure(8'd1, 8'd1);
        level_run(1'b1, 2);
        offer(1'b0);

        // Register extremes.
        run_phase(8'd1, 8'd1);
        run_phase(8'd255, 8'd255);
        run_phase(8'd255, 8'd1);
        run_phase(8'd1, 8'd255);

        // The receiver holds off while requests keep coming, so the block fills.
        settle();
        configure(8'd4, 8'd3);
        hold_off_req = 1'b1;
        repeat (30) offer(1'($urandom_range(0, 1)));
        run_phase(8'd2, 8'd2);

        repeat (4) run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
        repeat (2) run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));

        settle();
        if (sb.errors == 0)
            $display("tb_button_click_hold_gesture: PASS");
        else
            $display("tb_button_click_hold_gesture: FAIL");
        $finish;
    end

endmodule
